// ===== design/bpa_pkg.sv =====
// Shared types, constants and helper functions of the bitmap page allocator.
`default_nettype none

package bpa_pkg;

  localparam int unsigned CFG_W         = 13;
  localparam int unsigned IDX_W         = 12;
  localparam int unsigned WORD_W        = 32;
  localparam int unsigned DEF_MAX_PAGES = 4096;

  localparam logic [CFG_W-1:0] CNT_MAX   = 13'h1FFF;
  localparam logic [CFG_W-1:0] TOTAL_RST = 13'd4096;
  localparam logic [CFG_W-1:0] RES_RST   = 13'd1;

  // Configuration register indexes.
  localparam logic CFG_TOTAL    = 1'b0;
  localparam logic CFG_RESERVED = 1'b1;

  typedef enum logic {
    KIND_ALLOC = 1'b0,
    KIND_FREE  = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2,
    ST_FREE  = 2'd3
  } status_e;

  typedef struct packed {
    kind_e            kind;
    logic [IDX_W-1:0] page_index;
  } bpa_req_t;

  typedef struct packed {
    status_e          status;
    logic [IDX_W-1:0] page_index_out;
    logic [CFG_W-1:0] used_pages;
  } bpa_rsp_t;

  // Result of one request as the engine hands it to the output register.
  typedef struct packed {
    status_e          status;
    logic [IDX_W-1:0] page;
  } bpa_res_t;

  // Write enables of the two memories.
  typedef struct packed {
    logic map_we;
    logic sum_we;
  } bpa_wr_t;

  typedef struct packed {
    logic       found;
    logic [4:0] idx;
  } bpa_ffz_t;

  // Mask with all bits below position n set.
  function automatic logic [WORD_W-1:0] lo_mask(input logic [4:0] n);
    return (WORD_W'(1) << n) - WORD_W'(1);
  endfunction

  // Lowest clear bit of a word.
  function automatic bpa_ffz_t ffz(input logic [WORD_W-1:0] w);
    bpa_ffz_t r;
    r.found = ~&w;
    r.idx   = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (!w[i]) begin
        r.idx = 5'(i);
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== design/bpa_bitmap.sv =====
// Bitmap and full-word summary memories with the clearing pass after reset.
`default_nettype none

module bpa_bitmap import bpa_pkg::*; #(
  parameter int unsigned MAX_PAGES = DEF_MAX_PAGES,
  localparam int unsigned NUM_WORDS = (MAX_PAGES + WORD_W - 1) / WORD_W,
  localparam int unsigned NUM_SUM   = (NUM_WORDS + WORD_W - 1) / WORD_W,
  localparam int unsigned WA_W      = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1,
  localparam int unsigned SA_W      = (NUM_SUM > 1) ? $clog2(NUM_SUM) : 1
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire bpa_wr_t           wr_i,
  input  wire logic [WA_W-1:0]   map_waddr_i,
  input  wire logic [WORD_W-1:0] map_wdata_i,
  input  wire logic [SA_W-1:0]   sum_waddr_i,
  input  wire logic [WORD_W-1:0] sum_wdata_i,
  input  wire logic [WA_W-1:0]   map_raddr_i,
  input  wire logic [SA_W-1:0]   sum_raddr_i,
  output logic [WORD_W-1:0]      map_rdata_o,
  output logic [WORD_W-1:0]      sum_rdata_o,
  output logic                   busy_o
);

  logic [WORD_W-1:0] map_mem [NUM_WORDS];
  logic [WORD_W-1:0] sum_mem [NUM_SUM];

  logic [WA_W-1:0]   clr_q, clr_d;
  logic              busy_q, busy_d;

  logic              map_we, sum_we;
  logic [WA_W-1:0]   map_wa;
  logic [SA_W-1:0]   sum_wa;
  logic [WORD_W-1:0] map_wd, sum_wd;

  // The sweep walks every bitmap word once and clears the summary words on the way.
  always_comb begin
    clr_d  = clr_q;
    busy_d = busy_q;
    if (busy_q) begin
      clr_d = clr_q + WA_W'(1);
      if (clr_q == WA_W'(NUM_WORDS - 1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_comb begin
    if (busy_q) begin
      map_we = 1'b1;
      map_wa = clr_q;
      map_wd = '0;
      sum_we = ({1'b0, clr_q} < (WA_W + 1)'(NUM_SUM));
      sum_wa = SA_W'(clr_q);
      sum_wd = '0;
    end else begin
      map_we = wr_i.map_we;
      map_wa = map_waddr_i;
      map_wd = map_wdata_i;
      sum_we = wr_i.sum_we;
      sum_wa = sum_waddr_i;
      sum_wd = sum_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q  <= '0;
      busy_q <= 1'b1;
    end else begin
      clr_q  <= clr_d;
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (map_we) begin
      map_mem[map_wa] <= map_wd;
    end
    map_rdata_o <= map_mem[map_raddr_i];
  end

  always_ff @(posedge clk_i) begin
    if (sum_we) begin
      sum_mem[sum_wa] <= sum_wd;
    end
    sum_rdata_o <= sum_mem[sum_raddr_i];
  end

  assign busy_o = busy_q;

endmodule

`default_nettype wire

// ===== design/bpa_engine.sv =====
// Request sequencer: summary scan, bitmap read-modify-write and the used-page count.
`default_nettype none

module bpa_engine import bpa_pkg::*; #(
  parameter int unsigned MAX_PAGES = DEF_MAX_PAGES,
  localparam int unsigned NUM_WORDS = (MAX_PAGES + WORD_W - 1) / WORD_W,
  localparam int unsigned NUM_SUM   = (NUM_WORDS + WORD_W - 1) / WORD_W,
  localparam int unsigned WA_W      = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1,
  localparam int unsigned SA_W      = (NUM_SUM > 1) ? $clog2(NUM_SUM) : 1,
  localparam int unsigned SP_W      = (((SA_W + 10) > CFG_W) ? (SA_W + 10) : CFG_W) + 1
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire bpa_req_t          req_i,
  input  wire logic [CFG_W-1:0]  eff_total_i,
  input  wire logic [CFG_W-1:0]  eff_res_i,
  input  wire logic              clr_busy_i,
  output logic [WA_W-1:0]        map_raddr_o,
  output logic [SA_W-1:0]        sum_raddr_o,
  input  wire logic [WORD_W-1:0] map_rdata_i,
  input  wire logic [WORD_W-1:0] sum_rdata_i,
  output bpa_wr_t                wr_o,
  output logic [WA_W-1:0]        map_waddr_o,
  output logic [WORD_W-1:0]      map_wdata_o,
  output logic [SA_W-1:0]        sum_waddr_o,
  output logic [WORD_W-1:0]      sum_wdata_o,
  output logic                   res_valid_o,
  input  wire logic              res_ready_i,
  output bpa_res_t               res_o,
  output logic [CFG_W-1:0]       count_o
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_SUM     = 3'd1;
  localparam logic [2:0] S_SUMCHK  = 3'd2;
  localparam logic [2:0] S_MAPCHK  = 3'd3;
  localparam logic [2:0] S_FREE    = 3'd4;
  localparam logic [2:0] S_FREECHK = 3'd5;
  localparam logic [2:0] S_OUT     = 3'd6;

  logic [2:0]        state_q, state_d;
  logic [SP_W-1:0]   scan_q, scan_d;
  logic [WORD_W-1:0] hold_q, hold_d;
  bpa_res_t          res_q, res_d;
  logic [CFG_W-1:0]  cnt_q, cnt_d;

  logic [SP_W-1:0]   top_w, bot_w, cand_pg, next_blk, base, diff, next_word, got_pg;
  logic [WORD_W-1:0] sum_m, map_m, hi_m, set_bit, map_new, fbit, sbit;
  bpa_ffz_t          sum_f, map_f;

  assign top_w = SP_W'(eff_total_i);
  assign bot_w = SP_W'(eff_res_i);

  // Summary word: a set bit marks a bitmap word with every page in use.
  assign sum_m    = sum_rdata_i | lo_mask(scan_q[9:5]);
  assign sum_f    = ffz(sum_m);
  assign cand_pg  = (sum_f.idx == scan_q[9:5]) ? scan_q
                                               : {scan_q[SP_W-1:10], sum_f.idx, 5'd0};
  assign next_blk = (scan_q | SP_W'(10'h3FF)) + SP_W'(1);

  // Bitmap word: pages below the scan point or at or above the top count as taken.
  assign base      = {scan_q[SP_W-1:5], 5'd0};
  assign diff      = top_w - base;
  assign hi_m      = (diff >= SP_W'(WORD_W)) ? '0 : ~lo_mask(diff[4:0]);
  assign map_m     = map_rdata_i | lo_mask(scan_q[4:0]) | hi_m;
  assign map_f     = ffz(map_m);
  assign set_bit   = WORD_W'(1) << map_f.idx;
  assign map_new   = map_rdata_i | set_bit;
  assign next_word = base + SP_W'(WORD_W);
  assign got_pg    = base | SP_W'(map_f.idx);

  assign fbit = WORD_W'(1) << scan_q[4:0];
  assign sbit = WORD_W'(1) << scan_q[9:5];

  assign map_raddr_o = (state_q == S_SUMCHK) ? WA_W'(cand_pg[SP_W-1:5])
                                             : WA_W'(scan_q[SP_W-1:5]);
  assign sum_raddr_o = SA_W'(scan_q[SP_W-1:10]);
  assign map_waddr_o = WA_W'(scan_q[SP_W-1:5]);
  assign sum_waddr_o = SA_W'(scan_q[SP_W-1:10]);

  always_comb begin
    state_d     = state_q;
    scan_d      = scan_q;
    hold_d      = hold_q;
    res_d       = res_q;
    cnt_d       = cnt_q;
    wr_o        = '0;
    map_wdata_o = map_new;
    sum_wdata_o = hold_q | sbit;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i && in_ready_o) begin
          if (req_i.kind == KIND_ALLOC) begin
            scan_d  = bot_w;
            state_d = S_SUM;
          end else begin
            scan_d  = SP_W'(req_i.page_index);
            state_d = S_FREE;
          end
        end
      end
      S_SUM: begin
        if (scan_q >= top_w) begin
          res_d.status = ST_EMPTY;
          res_d.page   = '0;
          state_d      = S_OUT;
        end else begin
          state_d = S_SUMCHK;
        end
      end
      S_SUMCHK: begin
        if (!sum_f.found) begin
          if (next_blk >= top_w) begin
            res_d.status = ST_EMPTY;
            res_d.page   = '0;
            state_d      = S_OUT;
          end else begin
            scan_d  = next_blk;
            state_d = S_SUM;
          end
        end else if (cand_pg >= top_w) begin
          res_d.status = ST_EMPTY;
          res_d.page   = '0;
          state_d      = S_OUT;
        end else begin
          scan_d  = cand_pg;
          hold_d  = sum_rdata_i;
          state_d = S_MAPCHK;
        end
      end
      S_MAPCHK: begin
        if (map_f.found) begin
          wr_o.map_we  = 1'b1;
          wr_o.sum_we  = &map_new;
          if (cnt_q != CNT_MAX) begin
            cnt_d = cnt_q + CFG_W'(1);
          end
          res_d.status = ST_OK;
          res_d.page   = IDX_W'(got_pg);
          state_d      = S_OUT;
        end else if (next_word >= top_w) begin
          res_d.status = ST_EMPTY;
          res_d.page   = '0;
          state_d      = S_OUT;
        end else begin
          scan_d  = next_word;
          state_d = S_SUM;
        end
      end
      S_FREE: begin
        if (scan_q >= top_w || scan_q < bot_w) begin
          res_d.status = ST_RANGE;
          res_d.page   = '0;
          state_d      = S_OUT;
        end else begin
          state_d = S_FREECHK;
        end
      end
      S_FREECHK: begin
        res_d.page = '0;
        if (!map_rdata_i[scan_q[4:0]]) begin
          res_d.status = ST_FREE;
        end else begin
          // Clearing a page always leaves its word not full.
          wr_o.map_we  = 1'b1;
          wr_o.sum_we  = 1'b1;
          map_wdata_o  = map_rdata_i & ~fbit;
          sum_wdata_o  = sum_rdata_i & ~sbit;
          if (cnt_q != '0) begin
            cnt_d = cnt_q - CFG_W'(1);
          end
          res_d.status = ST_OK;
        end
        state_d = S_OUT;
      end
      S_OUT: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    scan_q <= scan_d;
    hold_q <= hold_d;
    res_q  <= res_d;
  end

  assign in_ready_o  = (state_q == S_IDLE) && !clr_busy_i;
  assign res_valid_o = (state_q == S_OUT);
  assign res_o       = res_q;
  assign count_o     = cnt_q;

endmodule

`default_nettype wire

// ===== design/bitmap_page_allocator.sv =====
// Top level of the first-fit bitmap page allocator.
//
// Usage: a request word on the in channel (req_i) either allocates the lowest
// free page at or above the reserved region and below total_pages, or frees
// the page it names. Every request gives exactly one response word on the out
// channel (rsp_o) with a status, the allocated page and the used-page count.
// Both channels use valid/ready. The cfg channel writes total_pages (index 0)
// and reserved_pages (index 1); it is always ready. The user must write it
// only while no request is in flight; the block itself does not enforce this.
// Sequence: an allocation reads a summary word (S_SUM), checks it (S_SUMCHK),
// then checks the chosen bitmap word (S_MAPCHK) before its result is valid
// (S_OUT); each further summary or bitmap word the scan visits sends it back
// to S_SUM. A free passes the range check (S_FREE) and the bitmap check
// (S_FREECHK); a range error goes from S_FREE to S_OUT. The scan reads the
// registered summary and bitmap memories in turn; one request is served at a time.
// Reset: a clearing pass writes all ceil(MAX_PAGES / 32) bitmap words (128 at
// the default size); no request is taken until it ends.
// Stall: the response sits in an output register, so the next request is
// taken while it waits; the engine then holds its result until that register
// frees up.
`default_nettype none

module bitmap_page_allocator import bpa_pkg::*; #(
  parameter int unsigned MAX_PAGES = DEF_MAX_PAGES,
  localparam int unsigned NUM_WORDS = (MAX_PAGES + WORD_W - 1) / WORD_W,
  localparam int unsigned NUM_SUM   = (NUM_WORDS + WORD_W - 1) / WORD_W,
  localparam int unsigned WA_W      = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1,
  localparam int unsigned SA_W      = (NUM_SUM > 1) ? $clog2(NUM_SUM) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_valid_i,
  output logic                  cfg_ready_o,
  input  wire logic             cfg_idx_i,
  input  wire logic [CFG_W-1:0] cfg_data_i,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire bpa_req_t         req_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output bpa_rsp_t              rsp_o
);

  logic [CFG_W-1:0]  total_q, total_d, resv_q, resv_d;
  logic [CFG_W-1:0]  eff_total, eff_res, count;
  logic [CFG_W:0]    used_sum;
  logic [CFG_W-1:0]  used;

  bpa_wr_t           wr;
  logic [WA_W-1:0]   map_raddr, map_waddr;
  logic [SA_W-1:0]   sum_raddr, sum_waddr;
  logic [WORD_W-1:0] map_rdata, sum_rdata, map_wdata, sum_wdata;
  logic              clr_busy;

  logic              eng_valid, eng_ready;
  bpa_res_t          eng_res;

  logic              out_valid_q, out_valid_d;
  bpa_rsp_t          rsp_q, rsp_d;

  // Configuration registers.
  assign cfg_ready_o = 1'b1;

  always_comb begin
    total_d = total_q;
    resv_d  = resv_q;
    if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_i)
        CFG_TOTAL:    total_d = cfg_data_i;
        CFG_RESERVED: resv_d  = cfg_data_i;
        default:      total_d = total_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= TOTAL_RST;
      resv_q  <= RES_RST;
    end else begin
      total_q <= total_d;
      resv_q  <= resv_d;
    end
  end

  // The managed range is clipped to the map depth, and the reserved region to
  // the managed range.
  assign eff_total = (32'(total_q) > MAX_PAGES) ? CFG_W'(MAX_PAGES) : total_q;
  assign eff_res   = (resv_q > eff_total) ? eff_total : resv_q;

  bpa_bitmap #(
    .MAX_PAGES(MAX_PAGES)
  ) u_bitmap (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_i        (wr),
    .map_waddr_i (map_waddr),
    .map_wdata_i (map_wdata),
    .sum_waddr_i (sum_waddr),
    .sum_wdata_i (sum_wdata),
    .map_raddr_i (map_raddr),
    .sum_raddr_i (sum_raddr),
    .map_rdata_o (map_rdata),
    .sum_rdata_o (sum_rdata),
    .busy_o      (clr_busy)
  );

  bpa_engine #(
    .MAX_PAGES(MAX_PAGES)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .req_i       (req_i),
    .eff_total_i (eff_total),
    .eff_res_i   (eff_res),
    .clr_busy_i  (clr_busy),
    .map_raddr_o (map_raddr),
    .sum_raddr_o (sum_raddr),
    .map_rdata_i (map_rdata),
    .sum_rdata_i (sum_rdata),
    .wr_o        (wr),
    .map_waddr_o (map_waddr),
    .map_wdata_o (map_wdata),
    .sum_waddr_o (sum_waddr),
    .sum_wdata_o (sum_wdata),
    .res_valid_o (eng_valid),
    .res_ready_i (eng_ready),
    .res_o       (eng_res),
    .count_o     (count)
  );

  // Used pages saturate at the counter limit.
  assign used_sum = {1'b0, eff_res} + {1'b0, count};
  assign used     = used_sum[CFG_W] ? CNT_MAX : used_sum[CFG_W-1:0];

  // Output register. The engine's count already reflects the finished request.
  assign eng_ready = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    rsp_d       = rsp_q;
    if (eng_valid && eng_ready) begin
      out_valid_d          = 1'b1;
      rsp_d.status         = eng_res.status;
      rsp_d.page_index_out = eng_res.page;
      rsp_d.used_pages     = used;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
  end

  assign out_valid_o = out_valid_q;
  assign rsp_o       = rsp_q;

  // No request is taken while the bitmap is being cleared.
  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy |-> !in_ready_o)
    else $error("request accepted during the clearing pass");

  // A result handed over by the engine shows up on the output next cycle.
  a_result_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    eng_valid && eng_ready |=> out_valid_o)
    else $error("engine result lost on the way to the output register");

  // Only a successful allocation reports a nonzero page.
  a_page_zero_on_fail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && rsp_o.status != ST_OK |-> rsp_o.page_index_out == '0)
    else $error("nonzero page with a failing status");

  // The used count never drops below the reserved region.
  a_used_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> rsp_o.used_pages >= eff_res)
    else $error("used pages below the reserved region");

endmodule

`default_nettype wire

// ===== verif/bitmap_page_allocator_tb.sv =====
// Self-checking testbench of the first-fit bitmap page allocator.
`timescale 1ns / 100ps

module bitmap_page_allocator_tb;
  import bpa_pkg::*;

  // Clock, reset and the ports of the block. Every input starts at a known value.
  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             cfg_valid_i = 1'b0;
  logic             cfg_ready_o;
  logic             cfg_idx_i   = CFG_TOTAL;
  logic [CFG_W-1:0] cfg_data_i  = '0;
  logic             in_valid_i  = 1'b0;
  logic             in_ready_o;
  bpa_req_t         req_i       = '0;
  logic             out_valid_o;
  logic             out_ready_i = 1'b0;
  bpa_rsp_t         rsp_o;

  bitmap_page_allocator dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .req_i       (req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .rsp_o       (rsp_o)
  );

  always #5 clk_i = ~clk_i;

  // Cycle count and a window in which neither side idles, so that
  // back-to-back words are seen as well as random gaps.
  int  cyc = 0;
  wire calm = (cyc >= 3000) && (cyc < 6000);

  // Our own view of the allocator: one mark per page, the count of pages
  // handed out, and the two limit registers as they were last written.
  bit               page_taken [DEF_MAX_PAGES];
  logic [CFG_W-1:0] taken_count  = '0;
  logic [CFG_W-1:0] total_reg    = TOTAL_RST;
  logic [CFG_W-1:0] reserved_reg = RES_RST;
  int               held_pages [$];   // pages currently marked, to pick frees from

  bpa_rsp_t rsp_owed [$];             // responses still due, oldest first
  int       mismatches = 0;

  // Works out the response to one request and applies its effect to the
  // mirrored map. The total is clipped to the map depth and the reserved
  // region to the total; reserved pages are never marked.
  function automatic bpa_rsp_t serve_request(bpa_req_t r);
    int       top;
    int       bottom;
    int       pg;
    int       sum;
    bpa_rsp_t s;
    top    = (total_reg > DEF_MAX_PAGES) ? DEF_MAX_PAGES : int'(total_reg);
    bottom = (reserved_reg > top) ? top : int'(reserved_reg);
    s      = '0;
    if (r.kind == KIND_ALLOC) begin
      for (pg = bottom; pg < top; pg++) begin
        if (!page_taken[pg]) break;
      end
      if (pg < top) begin
        page_taken[pg] = 1'b1;
        if (taken_count != CNT_MAX) taken_count++;
        held_pages.push_back(pg);
        s.status         = ST_OK;
        s.page_index_out = IDX_W'(pg);
      end else begin
        s.status = ST_EMPTY;
      end
    end else begin
      pg = int'(r.page_index);
      if (pg >= top || pg < bottom) begin
        s.status = ST_RANGE;
      end else if (!page_taken[pg]) begin
        s.status = ST_FREE;
      end else begin
        page_taken[pg] = 1'b0;
        if (taken_count != 0) taken_count--;
        foreach (held_pages[k]) begin
          if (held_pages[k] == pg) begin
            held_pages.delete(k);
            break;
          end
        end
        s.status = ST_OK;
      end
    end
    // The used count saturates; it may count pages twice after a limit change.
    sum          = bottom + int'(taken_count);
    s.used_pages = (sum > int'(CNT_MAX)) ? CNT_MAX : CFG_W'(sum);
    return s;
  endfunction

  // Offers one request word, idling now and then beforehand. Valid stays high
  // after acceptance so that the next word can follow without a gap. A row
  // with a typed response owes that response; the model still tracks it.
  task automatic push_req(bpa_req_t r, bit typed, bpa_rsp_t typed_rsp);
    bpa_rsp_t p;
    while (!calm && $urandom_range(0, 99) < 11) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    req_i      <= r;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    p = serve_request(r);
    rsp_owed.push_back(typed ? typed_rsp : p);
  endtask

  // Drops valid and waits until every owed response has come out, then idles on
  // so that the engine has surely gone idle.
  task automatic settle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (rsp_owed.size() != 0);
    repeat (8) @(posedge clk_i);
  endtask

  // Writes both limit registers back to back; only called while idle.
  task automatic set_limits(logic [CFG_W-1:0] total, logic [CFG_W-1:0] reserved);
    cfg_valid_i <= 1'b1;
    cfg_idx_i   <= CFG_TOTAL;
    cfg_data_i  <= total;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    total_reg   = total;
    cfg_idx_i   <= CFG_RESERVED;
    cfg_data_i  <= reserved;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    reserved_reg = reserved;
    cfg_valid_i <= 1'b0;
  endtask

  // Directed plan. A row either writes the limits or sends one request word.
  // The response is typed in where it is plain from the state (fresh reset,
  // the reserved page, the top page); other rows go to the model.
  typedef enum logic {
    ROW_REQ,
    ROW_CFG
  } row_e;

  typedef struct packed {
    row_e             act;
    kind_e            kind;
    logic [IDX_W-1:0] page;
    logic [CFG_W-1:0] total;
    logic [CFG_W-1:0] reserved;
    logic             typed;
    bpa_rsp_t         rsp;
  } plan_t;

  plan_t plan [30] = '{
    // Fresh map, page 0 reserved: allocations start at page 1.
    '{ROW_REQ, KIND_ALLOC, 12'd0,     13'd0,    13'd0,    1'b1, '{ST_OK,    12'd1, 13'd2}},
    '{ROW_REQ, KIND_ALLOC, 12'hFFF,   13'd0,    13'd0,    1'b1, '{ST_OK,    12'd2, 13'd3}},
    // Freeing the reserved page and a page that was never handed out.
    '{ROW_REQ, KIND_FREE,  12'd0,     13'd0,    13'd0,    1'b1, '{ST_RANGE, 12'd0, 13'd3}},
    '{ROW_REQ, KIND_FREE,  12'd4095,  13'd0,    13'd0,    1'b1, '{ST_FREE,  12'd0, 13'd3}},
    // A freed page is the first one handed out again.
    '{ROW_REQ, KIND_FREE,  12'd1,     13'd0,    13'd0,    1'b1, '{ST_OK,    12'd0, 13'd2}},
    '{ROW_REQ, KIND_ALLOC, 12'd0,     13'd0,    13'd0,    1'b1, '{ST_OK,    12'd1, 13'd3}},
    '{ROW_REQ, KIND_FREE,  12'hAAA,   13'd0,    13'd0,    1'b0, '0},
    '{ROW_REQ, KIND_FREE,  12'h555,   13'd0,    13'd0,    1'b0, '0},
    // Small map with the held pages now inside the reserved region; fill it
    // until it runs out.
    '{ROW_CFG, KIND_ALLOC, 12'd0,     13'd8,    13'd3,    1'b0, '0},
    '{ROW_REQ, KIND_ALLOC, 12'd0,     13'd0,    13'd0,    1'b0, '0},
    '{ROW_REQ, KIND_ALLOC, 12'd0,     13'd0,    13'd0,    1'b0, '0},
    '{ROW_REQ, KIND_ALLOC, 12'd0,     13'd0,    13'd0,    1'b0, '0},
    '{ROW_REQ, KIND_ALLOC, 12'd0,     13'd0,    13'd0,    1'b0, '0},
    '{ROW_REQ, KIND_ALLOC, 12'd0,     13'd0,    13'd0,    1'b0, '0},
    '{ROW_REQ, KIND_ALLOC, 12'd0,     13'd0,    13'd0,    1'b0, '0},
    '{ROW_REQ, KIND_FREE,  12'd8,     13'd0,    13'd0,    1'b0, '0},
    '{ROW_REQ, KIND_FREE,  12'd2,     13'd0,    13'd0,    1'b0, '0},
    // No page managed at all.
    '{ROW_CFG, KIND_ALLOC, 12'd0,     13'd0,    13'd0,    1'b0, '0},
    '{ROW_REQ, KIND_ALLOC, 12'd0,     13'd0,    13'd0,    1'b0, '0},
    '{ROW_REQ, KIND_FREE,  12'd0,     13'd0,    13'd0,    1'b0, '0},
    // Both limits at their widest: total clipped to the map, reserved to total.
    '{ROW_CFG, KIND_ALLOC, 12'd0,     13'd8191, 13'd8191, 1'b0, '0},
    '{ROW_REQ, KIND_ALLOC, 12'd0,     13'd0,    13'd0,    1'b0, '0},
    '{ROW_REQ, KIND_FREE,  12'd4095,  13'd0,    13'd0,    1'b0, '0},
    // No reserved region: page 0 can be taken and given back.
    '{ROW_CFG, KIND_ALLOC, 12'd0,     13'd4096, 13'd0,    1'b0, '0},
    '{ROW_REQ, KIND_ALLOC, 12'd0,     13'd0,    13'd0,    1'b0, '0},
    '{ROW_REQ, KIND_FREE,  12'd0,     13'd0,    13'd0,    1'b0, '0},
    '{ROW_REQ, KIND_FREE,  12'd0,     13'd0,    13'd0,    1'b0, '0},
    // A single managed page.
    '{ROW_CFG, KIND_ALLOC, 12'd0,     13'd1,    13'd0,    1'b0, '0},
    '{ROW_REQ, KIND_ALLOC, 12'd0,     13'd0,    13'd0,    1'b0, '0},
    '{ROW_REQ, KIND_ALLOC, 12'd0,     13'd0,    13'd0,    1'b0, '0}
  };

  // Limit settings of the random phases: the reset values, a region right at
  // the top of the map, reserved above total, total above the map depth, a
  // single usable page at the very top, and two picked at random.
  localparam int NUM_PHASES = 12;
  localparam int PHASE_LEN  = 120;
  logic [CFG_W-1:0] phase_total    [NUM_PHASES] =
    '{13'd4096, 13'd4096, 13'd64, 13'd1, 13'd100, 13'd8191, 13'd33, 13'd5000,
      13'd512,  13'd4096, 13'd0,  13'd0};
  logic [CFG_W-1:0] phase_reserved [NUM_PHASES] =
    '{13'd1,    13'd4000, 13'd0,  13'd1, 13'd200, 13'd0,    13'd31, 13'd4095,
      13'd100,  13'd0,    13'd0,  13'd0};

  initial begin : stimulus
    bpa_req_t r;
    int       roll;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].act == ROW_CFG) begin
        settle();
        set_limits(plan[i].total, plan[i].reserved);
      end else begin
        r.kind       = plan[i].kind;
        r.page_index = plan[i].page;
        push_req(r, plan[i].typed, plan[i].rsp);
      end
    end

    // Random phases. Most words allocate or free a page that is held, so the
    // map fills deep and frees land on real pages; the rest free anything.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph >= NUM_PHASES - 2) begin
        phase_total[ph]    = CFG_W'($urandom_range(1, 4200));
        phase_reserved[ph] = CFG_W'($urandom_range(0, phase_total[ph]));
      end
      settle();
      set_limits(phase_total[ph], phase_reserved[ph]);
      repeat (PHASE_LEN) begin
        roll         = $urandom_range(0, 99);
        r.page_index = IDX_W'($urandom_range(0, 4095));
        r.kind       = (roll < 55) ? KIND_ALLOC : KIND_FREE;
        if (roll >= 55 && roll < 85 && held_pages.size() != 0) begin
          r.page_index = IDX_W'(held_pages[$urandom_range(0, held_pages.size() - 1)]);
        end
        push_req(r, 1'b0, '0);
      end
    end

    // Drain, then leave a tail so that a stray extra word would be seen.
    settle();
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Response side: random back-pressure, and every accepted word is checked
  // field by field against the oldest owed response.
  always @(posedge clk_i) begin
    bpa_rsp_t want;
    cyc         <= cyc + 1;
    out_ready_i <= calm || ($urandom_range(0, 99) >= 11);
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (rsp_owed.size() == 0) begin
        mismatches++;
        $display("%0t: response word with none owed, got %p", $time, rsp_o);
      end else begin
        want = rsp_owed.pop_front();
        if (rsp_o.status !== want.status) begin
          mismatches++;
          $display("%0t: status expected %s got %s", $time, want.status.name(),
                   rsp_o.status.name());
        end
        if (rsp_o.page_index_out !== want.page_index_out) begin
          mismatches++;
          $display("%0t: page_index_out expected %0d got %0d", $time,
                   want.page_index_out, rsp_o.page_index_out);
        end
        if (rsp_o.used_pages !== want.used_pages) begin
          mismatches++;
          $display("%0t: used_pages expected %0d got %0d", $time,
                   want.used_pages, rsp_o.used_pages);
        end
      end
    end
  end

  // Hard stop far beyond the slowest correct run.
  initial begin : watchdog
    #5000000;
    $display("FAILURE");
    $finish;
  end

endmodule
